// ----- design/qpc_pkg.sv -----
// Shared types and constants for the quadrature position counter.
// Used by qpc_update and quadrature_position_counter_unit; depends on nothing.
package qpc_pkg;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_PRESET = 1'b1
  } qpc_req_e;

  // Configuration register indexes.
  localparam logic [2:0] CFG_STEP_SCALE        = 3'd0;
  localparam logic [2:0] CFG_DIRECTION_REVERSE = 3'd1;
  localparam logic [2:0] CFG_LIMITS_ENABLE     = 3'd2;
  localparam logic [2:0] CFG_MIN_LIMIT         = 3'd3;
  localparam logic [2:0] CFG_MAX_LIMIT         = 3'd4;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 32;

  // Pin states, A in bit 1 and B in bit 0, in forward Gray order.
  localparam logic [1:0] PINS_00 = 2'b00;
  localparam logic [1:0] PINS_01 = 2'b01;
  localparam logic [1:0] PINS_11 = 2'b11;
  localparam logic [1:0] PINS_10 = 2'b10;

  // Successor of each pin state for a forward and for a reverse step.
  localparam logic [1:0] FWD_NEXT [4] = '{PINS_01, PINS_11, PINS_00, PINS_10};
  localparam logic [1:0] REV_NEXT [4] = '{PINS_10, PINS_00, PINS_11, PINS_01};

  localparam logic signed [3:0] DETENT_UP   = 4'sd4;
  localparam logic signed [3:0] DETENT_DOWN = -4'sd4;

  typedef struct packed {
    logic               req_type;
    logic               clk_level;
    logic               dt_level;
    logic signed [31:0] preset_value;
  } qpc_in_t;

  typedef struct packed {
    logic signed [31:0] position_out;
    logic               moved;
  } qpc_out_t;

  typedef struct packed {
    logic [15:0]        step_scale;
    logic               direction_reverse;
    logic               limits_enable;
    logic signed [31:0] min_limit;
    logic signed [31:0] max_limit;
  } qpc_cfg_t;

  // Decoder phase: previous pins and the sub-step count within a detent.
  typedef struct packed {
    logic [1:0]        last_pins;
    logic signed [3:0] accum;
  } qpc_phase_t;

endpackage

// ----- design/qpc_update.sv -----
// Combinational next-state logic of the quadrature position counter: step
// decode, detent detection, position move with clamp or wrap, and preset.
// Depends on qpc_pkg.
module qpc_update #(
  parameter int unsigned PositionWidth = 32
) (
  input  qpc_pkg::qpc_in_t          item_i,
  input  qpc_pkg::qpc_cfg_t         cfg_i,
  input  logic [PositionWidth-1:0]  pos_i,
  input  qpc_pkg::qpc_phase_t       phase_i,
  output logic [PositionWidth-1:0]  pos_o,
  output qpc_pkg::qpc_phase_t       phase_o,
  output qpc_pkg::qpc_out_t         result_o
);

  // Clamp arithmetic runs wide enough for the saturated position plus one move.
  localparam int unsigned CW = (PositionWidth > 41) ? PositionWidth + 1 : 43;
  localparam logic signed [CW-1:0] BigBound    = {{(CW-41){1'b0}}, 1'b1, 40'b0};
  localparam logic signed [CW-1:0] NegBigBound = -BigBound;

  logic [1:0]              cur_pins;
  logic signed [3:0]       acc_sum;
  logic                    up, down, neg;
  logic [15:0]             mag;
  logic signed [CW-1:0]    delta;
  logic signed [CW-1:0]    pos_wide;
  logic signed [CW-1:0]    pos_sat;
  logic signed [CW-1:0]    moved_wide;
  logic signed [CW-1:0]    lo_wide, hi_wide;
  logic signed [CW-1:0]    clamped;
  logic [PositionWidth-1:0] pos_moved;

  always_comb begin
    cur_pins = {item_i.clk_level, item_i.dt_level};
    acc_sum  = phase_i.accum;
    if (qpc_pkg::FWD_NEXT[phase_i.last_pins] == cur_pins) begin
      acc_sum = phase_i.accum + 4'sd1;
    end else if (qpc_pkg::REV_NEXT[phase_i.last_pins] == cur_pins) begin
      acc_sum = phase_i.accum - 4'sd1;
    end
    up   = (acc_sum >= qpc_pkg::DETENT_UP);
    down = (acc_sum <= qpc_pkg::DETENT_DOWN);

    // A forward detent moves the position down unless the direction is reversed.
    neg   = up ^ cfg_i.direction_reverse;
    mag   = (cfg_i.step_scale == 16'd0) ? 16'd1 : cfg_i.step_scale;
    delta = neg ? -signed'(CW'(mag)) : signed'(CW'(mag));

    pos_wide = CW'(signed'(pos_i));
    if (pos_wide > BigBound) begin
      pos_sat = BigBound;
    end else if (pos_wide < NegBigBound) begin
      pos_sat = NegBigBound;
    end else begin
      pos_sat = pos_wide;
    end
    moved_wide = pos_sat + delta;
    lo_wide    = CW'(cfg_i.min_limit);
    hi_wide    = CW'(cfg_i.max_limit);
    if (moved_wide < lo_wide) begin
      clamped = lo_wide;
    end else if (moved_wide > hi_wide) begin
      clamped = hi_wide;
    end else begin
      clamped = moved_wide;
    end

    if (cfg_i.limits_enable) begin
      pos_moved = clamped[PositionWidth-1:0];
    end else begin
      pos_moved = pos_i + delta[PositionWidth-1:0];
    end

    phase_o         = phase_i;
    pos_o           = pos_i;
    result_o.moved  = 1'b0;
    if (qpc_pkg::qpc_req_e'(item_i.req_type) == qpc_pkg::REQ_PRESET) begin
      pos_o = PositionWidth'(item_i.preset_value);
    end else begin
      phase_o.last_pins = cur_pins;
      phase_o.accum     = acc_sum;
      if (up || down) begin
        pos_o          = pos_moved;
        phase_o.accum  = 4'sd0;
        result_o.moved = 1'b1;
      end
    end
    result_o.position_out = 32'(pos_o);
  end

endmodule

// ----- design/quadrature_position_counter_unit.sv -----
// Top level of the quadrature position counter: channel registers, decoder
// state, configuration registers and checks. Depends on qpc_pkg, qpc_update.
//
// Use: each input beat on in_* is either a sample of the encoder pins (A and B
// levels, already synchronized) or a preset of the position. Every input beat
// yields exactly one output beat carrying the position after that item and a
// moved flag that is set when the sample completed a four-step detent.
// An input beat is held in the input register, updated by one pass of
// combinational logic, and held again in the result register, from which it
// is presented as an output beat.
// Throughput: one item per cycle while the receiver keeps up; the input register
// and the result register both advance together, so a new beat is taken while
// the previous result waits. When the receiver stalls, the result register holds,
// the input register fills, and in_ready_o drops until out_ready_i returns.
// Configuration is a write port (enable, index, data); write it only while no
// item is in flight. Unknown indexes are ignored.
// Reset clears the position, the pin history and the sub-step count, loads the
// register defaults (scale 1, no reversal, no limits, full 32-bit limits) and
// empties both stages.
module quadrature_position_counter_unit #(
  parameter int unsigned PositionWidth = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  qpc_pkg::qpc_in_t                      in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output qpc_pkg::qpc_out_t                     out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [qpc_pkg::CfgIndexWidth-1:0]     cfg_index_i,
  input  logic [qpc_pkg::CfgDataWidth-1:0]      cfg_wdata_i
);

  logic                     in_valid_q;
  qpc_pkg::qpc_in_t         in_data_q;
  logic                     out_valid_q;
  qpc_pkg::qpc_out_t        out_data_q;
  qpc_pkg::qpc_cfg_t        cfg_q;
  logic [PositionWidth-1:0] pos_q, pos_d;
  qpc_pkg::qpc_phase_t      phase_q, phase_d;
  qpc_pkg::qpc_out_t        result;
  logic                     advance;

  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  qpc_update #(
    .PositionWidth(PositionWidth)
  ) u_update (
    .item_i  (in_data_q),
    .cfg_i   (cfg_q),
    .pos_i   (pos_q),
    .phase_i (phase_q),
    .pos_o   (pos_d),
    .phase_o (phase_d),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      phase_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          pos_q   <= pos_d;
          phase_q <= phase_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (advance && in_valid_q) begin
      out_data_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_scale        <= 16'd1;
      cfg_q.direction_reverse <= 1'b0;
      cfg_q.limits_enable     <= 1'b0;
      cfg_q.min_limit         <= 32'sh8000_0000;
      cfg_q.max_limit         <= 32'sh7FFF_FFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        qpc_pkg::CFG_STEP_SCALE:        cfg_q.step_scale        <= cfg_wdata_i[15:0];
        qpc_pkg::CFG_DIRECTION_REVERSE: cfg_q.direction_reverse <= cfg_wdata_i[0];
        qpc_pkg::CFG_LIMITS_ENABLE:     cfg_q.limits_enable     <= cfg_wdata_i[0];
        qpc_pkg::CFG_MIN_LIMIT:         cfg_q.min_limit         <= signed'(cfg_wdata_i);
        qpc_pkg::CFG_MAX_LIMIT:         cfg_q.max_limit         <= signed'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // The sub-step count never reaches a full detent in storage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q.accum <= 4'sd3) && (phase_q.accum >= -4'sd3))
    else $error("sub-step count left its range");

  // A completed detent leaves the sub-step count cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_valid_q && result.moved |=> phase_q.accum == 4'sd0)
    else $error("sub-step count not cleared after a detent");

  // A preset never disturbs the decoder phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_valid_q && in_data_q.req_type |=> $stable(phase_q))
    else $error("preset changed the decoder phase");

  // The input side stalls only when both stages are full and the output waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a full pipeline");

endmodule
